FILE: rtl/ocp_pkg.sv
// ----------------------------------------------------------------------------
// ocp_pkg: shared types and constants for overcurrent trip and switch control
// Register map, switch command codes, counter width and the channel
// interface structs.
// ----------------------------------------------------------------------------
package ocp_pkg;

    // Counter width of the debounce and recovery counters (8..32).
    localparam int CNT_W = 16;
    localparam int REG_W = 16;
    localparam int CUR_W = 16;
    // Compare width covering both a counter and a register value.
    localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;

    // Configuration register indexes
    localparam int          CFG_IDX_W           = 3;
    localparam logic [2:0]  REG_CHARGE_LIMIT    = 3'd0;
    localparam logic [2:0]  REG_CHARGE_DEB      = 3'd1;
    localparam logic [2:0]  REG_DISCHARGE_LIMIT = 3'd2;
    localparam logic [2:0]  REG_DISCHARGE_DEB   = 3'd3;
    localparam logic [2:0]  REG_RECOVERY_TICKS  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [REG_W-1:0] RST_LIMIT    = 16'd65535;
    localparam logic [REG_W-1:0] RST_DEBOUNCE = 16'd100;
    localparam logic [REG_W-1:0] RST_RECOVERY = 16'd3000; // 30 s of 10 ms ticks

    // Switch command codes
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_OFF  = 2'd1;
    localparam logic [1:0] CMD_ON   = 2'd2;

    typedef struct packed {
        logic [REG_W-1:0] limit;
        logic [REG_W-1:0] debounce;
    } chan_cfg_t;

    typedef struct packed {
        logic tripped;      // fault before this tick
        logic tripped_next; // fault after this tick
    } chan_stat_t;

    typedef struct packed {
        logic [1:0] chg_cmd;
        logic [1:0] dsg_cmd;
        logic       chg_log;
        logic       dsg_log;
    } cmd_out_t;

endpackage

FILE: rtl/ocp_chan.sv
// ----------------------------------------------------------------------------
// ocp_chan: one overcurrent channel
// Up/down trip debounce counter, tripped flag and recovery counter.
// ----------------------------------------------------------------------------
module ocp_chan
    import ocp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick,          // apply one tick this cycle
    input  logic [CUR_W-1:0] current,
    input  chan_cfg_t        cfg,
    input  logic [REG_W-1:0] recovery_ticks,
    output chan_stat_t       stat
);

    logic             tripped_reg,  tripped_next;
    logic [CNT_W-1:0] debounce_reg, debounce_next;
    logic [CNT_W-1:0] recovery_reg, recovery_next;

    always_comb begin
        tripped_next  = tripped_reg;
        debounce_next = debounce_reg;
        recovery_next = recovery_reg;
        if (tick) begin
            if (!tripped_reg) begin
                if (current > cfg.limit) begin
                    if (CMP_W'(cfg.debounce) <= CMP_W'(debounce_reg)) begin
                        debounce_next = '0;
                        tripped_next  = 1'b1;
                    end else begin
                        debounce_next = debounce_reg + CNT_W'(1);
                    end
                end else if (debounce_reg != '0) begin
                    debounce_next = debounce_reg - CNT_W'(1);
                end
            end else begin
                if (CMP_W'(recovery_ticks) <= CMP_W'(recovery_reg)) begin
                    recovery_next = '0;
                    tripped_next  = 1'b0;
                end else begin
                    recovery_next = recovery_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tripped_reg  <= 1'b0;
            debounce_reg <= '0;
            recovery_reg <= '0;
        end else begin
            tripped_reg  <= tripped_next;
            debounce_reg <= debounce_next;
            recovery_reg <= recovery_next;
        end
    end

    assign stat.tripped      = tripped_reg;
    assign stat.tripped_next = tripped_next;

`ifndef SYNTHESIS
    a_trip_clears_debounce: assert property (@(posedge aclk) disable iff (!aresetn)
        tripped_reg |-> (debounce_reg == '0))
        else $error("debounce count nonzero while tripped");

    a_idle_recovery_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !tripped_reg |-> (recovery_reg == '0))
        else $error("recovery count nonzero while not tripped");

    a_change_needs_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick |=> $stable(tripped_reg))
        else $error("tripped flag changed without a tick");
`endif

endmodule

FILE: rtl/ocp_cmd.sv
// ----------------------------------------------------------------------------
// ocp_cmd: switch command and fault log logic
// Turns fault edges and over-temperature changes into switch commands.
// ----------------------------------------------------------------------------
module ocp_cmd
    import ocp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tick,
    input  logic       over_temp,
    input  chan_stat_t chg,
    input  chan_stat_t dsg,
    output cmd_out_t   cmd
);

    logic heat_reg, heat_next;

    always_comb begin
        cmd       = '{chg_cmd: CMD_NONE, dsg_cmd: CMD_NONE, chg_log: 1'b0, dsg_log: 1'b0};
        heat_next = heat_reg;
        if (tick) begin
            if (!chg.tripped && chg.tripped_next) begin
                cmd.chg_log = 1'b1;
                cmd.chg_cmd = CMD_OFF;
            end else if (chg.tripped && !chg.tripped_next) begin
                cmd.chg_cmd = CMD_ON;
            end
            if (!dsg.tripped && dsg.tripped_next) begin
                cmd.dsg_log = 1'b1;
                cmd.dsg_cmd = CMD_OFF;
            end else if (dsg.tripped && !dsg.tripped_next) begin
                cmd.dsg_cmd = CMD_ON;
            end
            // the onset and the end of over-temperature override the fault commands
            if (!heat_reg) begin
                if (over_temp) begin
                    cmd.chg_cmd = CMD_OFF;
                    cmd.dsg_cmd = CMD_OFF;
                    heat_next   = 1'b1;
                end
            end else if (!over_temp) begin
                priority if (dsg.tripped_next) begin
                    cmd.chg_cmd = CMD_ON;
                end else if (chg.tripped_next) begin
                    cmd.dsg_cmd = CMD_ON;
                end else begin
                    cmd.chg_cmd = CMD_ON;
                    cmd.dsg_cmd = CMD_ON;
                end
                heat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_reg <= 1'b0;
        end else begin
            heat_reg <= heat_next;
        end
    end

endmodule

FILE: rtl/overcurrent_trip_and_switch_control.sv
// ----------------------------------------------------------------------------
// overcurrent_trip_and_switch_control: charge/discharge overcurrent trip
// Per 10 ms tick debounce, trip, recovery and switch command generation.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | one tick: currents, over-temp flag; tuser = tick due
//  m_axis   | out | one result per beat: faults, switch commands, log pulses
//  cfg      | in  | register write: 0..4 limits, debounce, recovery ticks
//
//  Throughput: one beat per cycle while the result is not stalled. Path:
//  input register, then result register; the tick's state update happens
//  when the beat moves from the input register to the result register.
//  Reset: aresetn synchronous, active low; clears all channel state and
//  loads the register defaults.
//  Stalls: the input register holds one beat while the result is stalled,
//  so s_tready drops only when both stages are full.
// ----------------------------------------------------------------------------
module overcurrent_trip_and_switch_control
    import ocp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] charge_current, [31:16] discharge_current, [32] over_temp
    input  logic [39:0]          s_tdata,
    // [0] tick_due
    input  logic                 s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] charge_fault, [1] discharge_fault, [3:2] charge_switch_cmd,
    // [5:4] discharge_switch_cmd, [6] charge_fault_logged,
    // [7] discharge_fault_logged
    output logic [7:0]           m_tdata,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]     cfg_wdata
);

    // configuration registers
    chan_cfg_t        chg_cfg_reg, dsg_cfg_reg;
    logic [REG_W-1:0] recovery_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chg_cfg_reg  <= '{limit: RST_LIMIT, debounce: RST_DEBOUNCE};
            dsg_cfg_reg  <= '{limit: RST_LIMIT, debounce: RST_DEBOUNCE};
            recovery_reg <= RST_RECOVERY;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CHARGE_LIMIT:    chg_cfg_reg.limit    <= cfg_wdata;
                REG_CHARGE_DEB:      chg_cfg_reg.debounce <= cfg_wdata;
                REG_DISCHARGE_LIMIT: dsg_cfg_reg.limit    <= cfg_wdata;
                REG_DISCHARGE_DEB:   dsg_cfg_reg.debounce <= cfg_wdata;
                REG_RECOVERY_TICKS:  recovery_reg         <= cfg_wdata;
                default: ;           // unmapped index: write dropped
            endcase
        end
    end

    // input register
    logic             in_valid_reg;
    logic             tick_due_reg;
    logic [CUR_W-1:0] chg_cur_reg, dsg_cur_reg;
    logic             over_temp_reg;

    logic out_free;   // result register can take a beat this cycle
    logic advance;    // beat moves from input to result register
    logic tick;       // advancing beat carries a due tick

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign tick     = advance && tick_due_reg;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_due_reg  <= s_tuser;
            chg_cur_reg   <= s_tdata[15:0];
            dsg_cur_reg   <= s_tdata[31:16];
            over_temp_reg <= s_tdata[32];
        end
    end

    // channels and command logic
    chan_stat_t chg_stat, dsg_stat;
    cmd_out_t   cmd;

    ocp_chan u_chg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (tick),
        .current        (chg_cur_reg),
        .cfg            (chg_cfg_reg),
        .recovery_ticks (recovery_reg),
        .stat           (chg_stat)
    );

    ocp_chan u_dsg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (tick),
        .current        (dsg_cur_reg),
        .cfg            (dsg_cfg_reg),
        .recovery_ticks (recovery_reg),
        .stat           (dsg_stat)
    );

    ocp_cmd u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .over_temp (over_temp_reg),
        .chg       (chg_stat),
        .dsg       (dsg_stat),
        .cmd       (cmd)
    );

    // result register; with no tick the faults pass through unchanged and
    // the commands read as none (tripped_next equals tripped then)
    logic       out_valid_reg;
    logic [7:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {cmd.dsg_log, cmd.chg_log, cmd.dsg_cmd, cmd.chg_cmd,
                             dsg_stat.tripped_next, chg_stat.tripped_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_log_has_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !((m_tdata[6] && !m_tdata[0]) || (m_tdata[7] && !m_tdata[1])))
        else $error("fault logged but fault flag clear");

    a_cmd_code_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:2] == CMD_NONE) || (m_tdata[3:2] == CMD_OFF)
                      || (m_tdata[3:2] == CMD_ON))
                  && ((m_tdata[5:4] == CMD_NONE) || (m_tdata[5:4] == CMD_OFF)
                      || (m_tdata[5:4] == CMD_ON)))
        else $error("unused switch command code");

    a_hold_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("input beat lost while result stalled");
`endif

endmodule
